// File: design/mer_pkg.sv
package mer_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int AXIS_BITS_DEF  = 11;

  // command codes on the op field
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // drawing phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_R1   = 4'b0010,
    PH_R2   = 4'b0100,
    PH_FIN  = 4'b1000
  } phase_t;

endpackage

// File: design/mer_cmd_if.sv
interface mer_cmd_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [AXIS_BITS-1:0]  semi_axis_x;
  logic [AXIS_BITS-1:0]  semi_axis_y;

  modport source (
    output valid, op, center_x, center_y, semi_axis_x, semi_axis_y,
    input  ready
  );
  modport sink (
    input  valid, op, center_x, center_y, semi_axis_x, semi_axis_y,
    output ready
  );
endinterface

// File: design/mer_pnt_if.sv
interface mer_pnt_if #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] point_x;
  logic signed [COORD_BITS+1:0] point_y;
  logic                         last_of_step;
  logic                         drawing_done;

  modport source (
    output valid, point_x, point_y, last_of_step, drawing_done,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, last_of_step, drawing_done,
    output ready
  );
endinterface

// File: design/midpoint_ellipse_rasterizer_core.sv
// start command: busy after the transfer while it forms a^2, b^2, a^2*b, then the prime
// advance command: 4 point transfers, one per cycle at the earliest, then the decision
//   update (MX, MY, UPD); on the step that crosses into region two also TX, TY, BT, AT, ABP, PRIME2
// pacing: the products of each step go one after another through the single shared multiplier
// one item at a time: cmd.ready is high only while the sequencer is idle
// rst (synchronous) returns the sequencer and drawing phase to idle
module midpoint_ellipse_rasterizer_core #(
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mer_cmd_if.sink     cmd,
  mer_pnt_if.source   pnt
);
  import mer_pkg::*;

  // multiplier operand width covers (2x+1)^2 and the squared semi-axes
  localparam int MW = 2 * AXIS_BITS + 2;
  localparam int PW = 2 * MW;
  // scaled decision value, signed
  localparam int DW = 4 * AXIS_BITS + 8;
  localparam int OW = COORD_BITS + 2;
  localparam int SW = OW + AXIS_BITS;
  localparam int QW = 2 * AXIS_BITS;

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_SQA    = 15'b000000000000010,
    ST_SQB    = 15'b000000000000100,
    ST_AB     = 15'b000000000001000,
    ST_PRIME1 = 15'b000000000010000,
    ST_EMIT   = 15'b000000000100000,
    ST_MX     = 15'b000000001000000,
    ST_MY     = 15'b000000010000000,
    ST_UPD    = 15'b000000100000000,
    ST_TX     = 15'b000001000000000,
    ST_TY     = 15'b000010000000000,
    ST_BT     = 15'b000100000000000,
    ST_AT     = 15'b001000000000000,
    ST_ABP    = 15'b010000000000000,
    ST_PRIME2 = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  phase_t phase;

  // latched ellipse
  logic [COORD_BITS-1:0] cx, cy;
  logic [AXIS_BITS-1:0]  ra, rb;
  logic [QW-1:0]         a2, b2;
  // walk point
  logic [AXIS_BITS-1:0]  x, y;
  logic signed [DW-1:0]  decision;
  // shared multiplier and scratch products
  logic [MW-1:0]         mul_a, mul_b;
  logic [PW-1:0]         prod, t1, t2;
  // emit bookkeeping
  logic [1:0]            k;
  logic                  done_flag;
  // branch taken on this step: region one x-only, region two y-only
  logic                  br;

  logic                  cmd_xfer, pnt_xfer;
  logic                  dec_neg, dec_pos, br_now;
  logic [AXIS_BITS:0]    tx;
  logic [AXIS_BITS-1:0]  ty_abs;
  logic                  in_r1, xstep, ystep;
  logic [DW-1:0]         bx8, ay8, inc_c;
  logic [SW-1:0]         xp_w, xm_w, yp_w, ym_w;

  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign pnt_xfer  = pnt.valid && pnt.ready;
  assign cmd.ready = (state == ST_IDLE);
  assign pnt.valid = (state == ST_EMIT);

  assign dec_neg = decision[DW-1];
  assign dec_pos = !dec_neg && (decision != '0);
  assign in_r1   = (phase == PH_R1);
  // region one takes the x-only branch on a negative value, region two the y-only branch on a positive one
  assign br_now  = in_r1 ? dec_neg : dec_pos;

  // terms for region two prime: (2x+1) and |y-1|
  assign tx     = {x, 1'b1};
  assign ty_abs = (y == '0) ? AXIS_BITS'(1) : y - AXIS_BITS'(1);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQA: begin
        mul_a = MW'(ra);
        mul_b = MW'(ra);
      end
      ST_SQB: begin
        mul_a = MW'(rb);
        mul_b = MW'(rb);
      end
      ST_AB: begin
        mul_a = MW'(a2);
        mul_b = MW'(rb);
      end
      ST_MX: begin
        mul_a = MW'(b2);
        mul_b = MW'(x);
      end
      ST_MY: begin
        mul_a = MW'(a2);
        mul_b = MW'(y);
      end
      ST_TX: begin
        mul_a = MW'(tx);
        mul_b = MW'(tx);
      end
      ST_TY: begin
        mul_a = MW'(ty_abs);
        mul_b = MW'(ty_abs);
      end
      ST_BT: begin
        mul_a = MW'(b2);
        mul_b = t1[MW-1:0];
      end
      ST_AT: begin
        mul_a = MW'(a2);
        mul_b = t2[MW-1:0];
      end
      ST_ABP: begin
        mul_a = MW'(a2);
        mul_b = MW'(b2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // step update terms: t1 holds b^2*x, prod holds a^2*y (both updated values)
  assign xstep = in_r1 ? 1'b1 : !br;
  assign ystep = in_r1 ? !br : 1'b1;
  assign bx8   = xstep ? (DW'(t1) << 3) : '0;
  assign ay8   = ystep ? (DW'(prod) << 3) : '0;
  assign inc_c = in_r1 ? (DW'(b2) << 2) : (DW'(a2) << 2);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          if (cmd.op == OP_START) begin
            state_next = ST_SQA;
          end else if (phase == PH_R1 || phase == PH_R2) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SQA:    state_next = ST_SQB;
      ST_SQB:    state_next = ST_AB;
      ST_AB:     state_next = ST_PRIME1;
      ST_PRIME1: state_next = ST_IDLE;
      ST_EMIT: begin
        if (pnt_xfer && k == 2'd3) begin
          state_next = done_flag ? ST_IDLE : ST_MX;
        end
      end
      ST_MX:     state_next = ST_MY;
      ST_MY:     state_next = ST_UPD;
      ST_UPD: begin
        // shallow slope ends once b^2*x exceeds a^2*y
        state_next = (in_r1 && (t1 > prod)) ? ST_TX : ST_IDLE;
      end
      ST_TX:     state_next = ST_TY;
      ST_TY:     state_next = ST_BT;
      ST_BT:     state_next = ST_AT;
      ST_AT:     state_next = ST_ABP;
      ST_ABP:    state_next = ST_PRIME2;
      ST_PRIME2: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_IDLE;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && cmd_xfer && cmd.op == OP_START) begin
        phase <= PH_R1;
      end else if (state == ST_EMIT && pnt_xfer && k == 2'd3 && done_flag) begin
        phase <= PH_FIN;
      end else if (state == ST_PRIME2) begin
        phase <= PH_R2;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= PW'(mul_a * mul_b);
    case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          if (cmd.op == OP_START) begin
            cx <= cmd.center_x;
            cy <= cmd.center_y;
            ra <= cmd.semi_axis_x;
            rb <= cmd.semi_axis_y;
            x  <= '0;
            y  <= cmd.semi_axis_y;
          end else begin
            done_flag <= (y == '0);
            k         <= 2'd0;
          end
        end
      end
      ST_SQB: a2 <= prod[QW-1:0];
      ST_AB:  b2 <= prod[QW-1:0];
      ST_PRIME1: begin
        // 4b^2 - 4a^2*b + a^2
        decision <= (DW'(b2) << 2) - (DW'(prod) << 2) + DW'(a2);
      end
      ST_EMIT: begin
        if (pnt_xfer) begin
          k <= k + 2'd1;
          if (k == 2'd3 && !done_flag) begin
            // move the walk point before the products are formed
            br <= br_now;
            if (in_r1) begin
              x <= x + AXIS_BITS'(1);
              if (!br_now) begin
                y <= y - AXIS_BITS'(1);
              end
            end else begin
              y <= y - AXIS_BITS'(1);
              if (!br_now) begin
                x <= x + AXIS_BITS'(1);
              end
            end
          end
        end
      end
      ST_MY:  t1 <= prod;
      ST_UPD: decision <= decision + bx8 - ay8 + inc_c;
      ST_TY:  t1 <= prod;
      ST_BT:  t2 <= prod;
      ST_AT:  t1 <= prod;
      ST_ABP: t2 <= prod;
      ST_PRIME2: begin
        // b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2b^2
        decision <= DW'(t1) + (DW'(t2) << 2) - (DW'(prod) << 2);
      end
      default: begin
      end
    endcase
  end

  // mirror points: plus/minus x on k[1], plus/minus y on k[0]
  assign xp_w = SW'(cx) + SW'(x);
  assign xm_w = SW'(cx) - SW'(x);
  assign yp_w = SW'(cy) + SW'(y);
  assign ym_w = SW'(cy) - SW'(y);

  assign pnt.point_x      = $signed(k[1] ? xm_w[OW-1:0] : xp_w[OW-1:0]);
  assign pnt.point_y      = $signed(k[0] ? ym_w[OW-1:0] : yp_w[OW-1:0]);
  assign pnt.last_of_step = (k == 2'd3);
  assign pnt.drawing_done = done_flag;

  // never ready for a command while points are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    pnt.valid |-> !cmd.ready)
    else $error("command ready while emitting points");

  // the fourth point closes the step
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (pnt.valid && pnt.ready && pnt.last_of_step) |=> !pnt.valid)
    else $error("points continue after last of step");

  // advance with no drawing in progress emits nothing
  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.op == OP_ADVANCE &&
     (phase == PH_IDLE || phase == PH_FIN)) |=> !pnt.valid)
    else $error("points emitted without an active drawing");

  // done flag holds across the points of one step
  a_done_stable: assert property (@(posedge clk) disable iff (rst)
    (pnt.valid && $past(pnt.valid)) |-> $stable(pnt.drawing_done))
    else $error("done flag changed within a step");

endmodule

// File: test/midpoint_ellipse_rasterizer_core_tb.sv
module midpoint_ellipse_rasterizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mer_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int AW = AXIS_BITS_DEF;
  localparam int PW = CW + 2;

  // directed rows, random items, output choke, settle time, hard stop
  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_ITEMS  = 125;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500_000;

  // one plotted mirror point as it leaves the block
  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
    logic                 last;
    logic                 done;
  } spot_t;

  // hand-written outcome of a table row; when not known the model decides
  // the four mirror points are (x_hi,y_hi) (x_hi,y_lo) (x_lo,y_hi) (x_lo,y_lo)
  typedef struct packed {
    bit                   known;
    bit [2:0]             count;
    logic signed [PW-1:0] x_hi;
    logic signed [PW-1:0] x_lo;
    logic signed [PW-1:0] y_hi;
    logic signed [PW-1:0] y_lo;
    bit                   done;
  } gold_t;

  // one command on the input channel plus what it should produce
  typedef struct packed {
    logic          op;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
    gold_t         gold;
  } row_t;

  logic clk;
  logic rst = 1'b1;

  mer_cmd_if cmd_bus ();
  mer_pnt_if pnt_bus ();

  midpoint_ellipse_rasterizer_core i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .pnt (pnt_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // row on offer, driven together with the command payload
  row_t offer = '0;

  // shared knobs: no idling on either side, and a one-shot output choke
  bit no_gaps   = 1'b0;
  bit choke_req = 1'b0;

  // mirror points still owed by the block, oldest first
  spot_t points_due[$];
  spot_t step_pts[4];

  int unsigned mismatch_count = 0;
  int unsigned points_checked = 0;
  int unsigned items_taken    = 0;
  int unsigned starts_seen    = 0;
  int unsigned steps_seen     = 0;
  int unsigned ellipses_done  = 0;
  int unsigned cycle_count    = 0;

  // walk state of the predicted ellipse
  bit [CW-1:0] ell_cx, ell_cy;
  bit [AW-1:0] walk_x, walk_y;
  bit [63:0]   a_sq, b_sq, dec4;
  phase_t      walk_phase;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // midpoint walk; dec4 is the decision value times four, sign at bit 63
  task automatic predict_item(input logic op, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [AW-1:0] ax, input logic [AW-1:0] ay,
                              output int n);
    bit [PW-1:0] xp, xm, yp, ym;
    bit          fin, neg, pos;
    bit [63:0]   slope_x, slope_y, tx, ty;
    n = 0;
    if (op == OP_START) begin
      // latch and restart, even in the middle of a drawing
      ell_cx     = cx;
      ell_cy     = cy;
      a_sq       = 64'(ax) * 64'(ax);
      b_sq       = 64'(ay) * 64'(ay);
      walk_x     = '0;
      walk_y     = ay;
      dec4       = 64'd4 * b_sq - 64'd4 * a_sq * 64'(ay) + a_sq;
      walk_phase = PH_R1;
    end else if (walk_phase == PH_R1 || walk_phase == PH_R2) begin
      // emit the four mirrors of the current point, wrapping at the output width
      fin = (walk_y == '0);
      xp  = ell_cx + walk_x;
      xm  = ell_cx - walk_x;
      yp  = ell_cy + walk_y;
      ym  = ell_cy - walk_y;
      for (int k = 0; k < 4; k++) begin
        step_pts[k].x    = k[1] ? xm : xp;
        step_pts[k].y    = k[0] ? ym : yp;
        step_pts[k].last = (k == 3);
        step_pts[k].done = fin;
      end
      n = 4;
      if (fin) begin
        walk_phase = PH_FIN;
      end else if (walk_phase == PH_R1) begin
        // shallow slope: x moves every step
        neg    = dec4[63];
        walk_x = walk_x + 1'b1;
        if (neg) begin
          dec4 = dec4 + 64'd8 * b_sq * 64'(walk_x) + 64'd4 * b_sq;
        end else begin
          walk_y = walk_y - 1'b1;
          dec4   = dec4 + 64'd8 * b_sq * 64'(walk_x) - 64'd8 * a_sq * 64'(walk_y)
                   + 64'd4 * b_sq;
        end
        slope_x = 64'd2 * b_sq * 64'(walk_x);
        slope_y = 64'd2 * a_sq * 64'(walk_y);
        if (slope_x > slope_y) begin
          // crossing into the steep part, decision primed afresh
          tx         = 64'd2 * 64'(walk_x) + 64'd1;
          ty         = 64'(walk_y) - 64'd1;
          dec4       = b_sq * tx * tx + 64'd4 * a_sq * ty * ty - 64'd4 * a_sq * b_sq;
          walk_phase = PH_R2;
        end
      end else begin
        // steep slope: y moves every step
        pos    = !dec4[63] && (dec4 != '0);
        walk_y = walk_y - 1'b1;
        if (pos) begin
          dec4 = dec4 + 64'd4 * a_sq - 64'd8 * a_sq * 64'(walk_y);
        end else begin
          walk_x = walk_x + 1'b1;
          dec4   = dec4 + 64'd8 * b_sq * 64'(walk_x) - 64'd8 * a_sq * 64'(walk_y)
                   + 64'd4 * a_sq;
        end
      end
    end
  endtask

  // observe both channels at each edge: commands first, then points
  always @(posedge clk) begin
    int    n;
    spot_t want;
    spot_t got;
    if (rst) begin
      ell_cx     = '0;
      ell_cy     = '0;
      walk_x     = '0;
      walk_y     = '0;
      a_sq       = '0;
      b_sq       = '0;
      dec4       = '0;
      walk_phase = PH_IDLE;
      points_due.delete();
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        items_taken++;
        predict_item(cmd_bus.op, cmd_bus.center_x, cmd_bus.center_y,
                     cmd_bus.semi_axis_x, cmd_bus.semi_axis_y, n);
        if (cmd_bus.op == OP_START) begin
          starts_seen++;
        end else if (n != 0) begin
          steps_seen++;
          if (step_pts[0].done) begin
            ellipses_done++;
          end
        end
        if (offer.gold.known) begin
          // hand-written rows override the model's points
          for (int k = 0; k < offer.gold.count; k++) begin
            want.x    = k[1] ? offer.gold.x_lo : offer.gold.x_hi;
            want.y    = k[0] ? offer.gold.y_lo : offer.gold.y_hi;
            want.last = (k == 3);
            want.done = offer.gold.done;
            points_due.push_back(want);
          end
        end else begin
          for (int k = 0; k < n; k++) begin
            points_due.push_back(step_pts[k]);
          end
        end
      end
      if (pnt_bus.valid && pnt_bus.ready) begin
        got.x    = pnt_bus.point_x;
        got.y    = pnt_bus.point_y;
        got.last = pnt_bus.last_of_step;
        got.done = pnt_bus.drawing_done;
        if (points_due.size() == 0) begin
          flag_mismatch($sformatf("point (%0d,%0d) with nothing pending", got.x, got.y));
        end else begin
          want = points_due.pop_front();
          points_checked++;
          if (got.x !== want.x) begin
            flag_mismatch($sformatf("point_x %0d, want %0d", got.x, want.x));
          end
          if (got.y !== want.y) begin
            flag_mismatch($sformatf("point_y %0d, want %0d", got.y, want.y));
          end
          if (got.last !== want.last) begin
            flag_mismatch($sformatf("last_of_step %b, want %b", got.last, want.last));
          end
          if (got.done !== want.done) begin
            flag_mismatch($sformatf("drawing_done %b, want %b", got.done, want.done));
          end
        end
      end
    end
  end

  // point receiver: random ready gaps, plus one long choke on request
  initial begin
    int unsigned gap;
    pnt_bus.ready = 1'b0;
    wait (!rst);
    forever begin
      if (choke_req) begin
        pnt_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        choke_req = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        pnt_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pnt_bus.ready <= 1'b1;
      do @(posedge clk); while (!pnt_bus.valid);
    end
  end

  // hard stop on a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  function automatic row_t start_row(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                                     input logic [AW-1:0] ax, input logic [AW-1:0] ay);
    row_t r;
    r            = '0;
    r.op         = OP_START;
    r.cx         = cx;
    r.cy         = cy;
    r.ax         = ax;
    r.ay         = ay;
    r.gold.known = 1'b1;
    return r;
  endfunction

  // advance with junk in the unused fields
  function automatic row_t step_row();
    row_t r;
    r    = '0;
    r.op = OP_ADVANCE;
    r.cx = CW'($urandom);
    r.cy = CW'($urandom);
    r.ax = AW'($urandom);
    r.ay = AW'($urandom);
    return r;
  endfunction

  function automatic row_t step_known(input int count, input int x_hi, input int x_lo,
                                      input int y_hi, input int y_lo, input bit done);
    row_t r;
    r            = step_row();
    r.gold.known = 1'b1;
    r.gold.count = 3'(count);
    r.gold.x_hi  = PW'(x_hi);
    r.gold.x_lo  = PW'(x_lo);
    r.gold.y_hi  = PW'(y_hi);
    r.gold.y_lo  = PW'(y_lo);
    r.gold.done  = done;
    return r;
  endfunction

  task automatic offer_item(input row_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.op          <= r.op;
    cmd_bus.center_x    <= r.cx;
    cmd_bus.center_y    <= r.cy;
    cmd_bus.semi_axis_x <= r.ax;
    cmd_bus.semi_axis_y <= r.ay;
    offer               <= r;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // one start and a run of advances on it
  task automatic draw_ellipse(input logic [AW-1:0] ax, input logic [AW-1:0] ay,
                              input int unsigned steps);
    offer_item(start_row(CW'($urandom), CW'($urandom), ax, ay));
    repeat (steps) offer_item(step_row());
  endtask

  // stop offering until every owed point has come out
  task automatic drain_points();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (points_due.size() != 0) @(posedge clk);
  endtask

  // stimulus: directed table, then random ellipses and noise
  initial begin
    row_t        script[DIRECTED_ROWS];
    int unsigned a, b, kind, iter, base;
    cmd_bus.valid       = 1'b0;
    cmd_bus.op          = OP_START;
    cmd_bus.center_x    = '0;
    cmd_bus.center_y    = '0;
    cmd_bus.semi_axis_x = '0;
    cmd_bus.semi_axis_y = '0;

    script = '{
      // advance straight out of reset does nothing
      step_known(0, 0, 0, 0, 0, 1'b0),
      // zero vertical axis: one step at the centre, final
      start_row(100, 200, 10, 0),
      step_known(4, 100, 100, 200, 200, 1'b1),
      // finished drawing ignores advances
      step_known(0, 0, 0, 0, 0, 1'b0),
      // largest axes at the origin, mirrors go negative
      start_row(0, 0, 2047, 2047),
      step_known(4, 0, 0, 2047, -2047, 1'b0),
      step_row(), step_row(), step_row(),
      // far corner with unit axes, mirrors past the coordinate range
      start_row(4095, 4095, 1, 1),
      step_known(4, 4095, 4095, 4096, 4094, 1'b0),
      step_row(), step_row(), step_row(),
      // zero horizontal axis, walks by the same rules
      start_row(2048, 1024, 0, 5),
      step_known(4, 2048, 2048, 1029, 1019, 1'b0),
      step_row(), step_row(), step_row(), step_row(),
      // restart in the middle of a drawing
      start_row(12'hAAA, 12'h555, 5, 3),
      step_row(), step_row(),
      start_row(12'h555, 12'hAAA, 11'h2AA, 11'h555),
      step_known(4, 12'h555, 12'h555, 4095, 1365, 1'b0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      offer_item(script[i]);
    end
    drain_points();

    // mostly complete small ellipses; some noise, broken and degenerate runs
    base = items_taken;
    iter = 0;
    while (items_taken < base + RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if (iter == 2) begin
        choke_req = 1'b1;
      end
      if (iter == 6) begin
        drain_points();
      end
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        a = $urandom_range(1, 24);
        b = $urandom_range(1, 24);
        draw_ellipse(AW'(a), AW'(b), a + b + 2);
      end else if (kind == 7) begin
        offer_item(step_row());
      end else if (kind == 8) begin
        // any axes, abandoned after a few steps
        draw_ellipse(AW'($urandom), AW'($urandom), $urandom_range(1, 6));
      end else begin
        a = $urandom_range(1, 24);
        b = $urandom_range(1, 24);
        if ($urandom_range(0, 1) == 0) begin
          a = 0;
        end else begin
          b = 0;
        end
        draw_ellipse(AW'(a), AW'(b), a + b + 2);
      end
      iter++;
    end

    no_gaps = 1'b0;
    drain_points();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d starts, %0d plotting steps, %0d ellipses walked to the end",
             starts_seen, steps_seen, ellipses_done);
    $display("%0d points compared, long output choke and drain pauses included, %0d cycles",
             points_checked, cycle_count);
    if (mismatch_count == 0 && points_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
